@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the truncated mean profile RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge outside reset
`define ASSERT_AT(lbl, expr, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that a trigger implies a consequence in the same cycle
`define ASSERT_IMPL(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ rtl/core/tmp_pkg.sv @@
// Shared types and constants for the truncated mean profile block
package tmp_pkg;
	localparam int VAL_W      = 24;
	localparam int IDX_W      = 16;
	localparam int RAD_W      = 16;
	localparam int SIG_W      = 12;
	localparam int CFG_ADDR_W = 1;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_ADDR_W-1:0] REG_RADIUS = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_SIGMA  = 1'b1;

	localparam logic [RAD_W-1:0] RADIUS_RST = 16'd256;
	localparam logic [SIG_W-1:0] SIGMA_RST  = 12'd256;

	typedef struct packed {
		logic [VAL_W-1:0] range_value;
		logic [VAL_W-1:0] charge_value;
		logic             last_point;
	} point_t;

	typedef struct packed {
		logic [VAL_W-1:0] clipped_mean;
		logic [IDX_W-1:0] point_index;
		logic             last_result;
	} result_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SETUP,
		ST_CREAD,
		ST_CLOAD,
		ST_GREAD,
		ST_GCMP,
		ST_GDONE,
		ST_MREAD,
		ST_MCMP,
		ST_VSTART,
		ST_MSQ,
		ST_SQS,
		ST_VDIV,
		ST_WVDIV,
		ST_SQRT,
		ST_WSQRT,
		ST_THR,
		ST_KREAD,
		ST_KCMP,
		ST_KDONE,
		ST_WMDIV,
		ST_RES
	} state_t;

	typedef struct packed {
		logic store;
		logic d_load;
		logic setup;
		logic rd_centre;
		logic cload;
		logic gcmp;
		logic mstart;
		logic mcmp;
		logic mean_own;
		logic var_start;
		logic msq_step;
		logic sqs;
		logic vdiv_go;
		logic sqrt_go;
		logic rms_load;
		logic rms_zero;
		logic thr;
		logic kstart;
		logic kcmp;
		logic mdiv_go;
		logic mean_div;
		logic mean_zero;
		logic res_load;
		logic next_d;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic emit_needed;
		logic d_zero;
		logic gather_last;
		logic m_zero;
		logic m_small;
		logic j_last;
		logic med_hit;
		logic cnt_zero;
		logic div_busy;
		logic sqrt_busy;
		logic i_last;
		logic npts_zero;
		logic out_free;
	} sts_t;
endpackage

@@ rtl/core/tmp_if.sv @@
// Point and result stream interfaces
interface tmp_point_if;
	logic            valid;
	logic            ready;
	tmp_pkg::point_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface tmp_result_if;
	logic             valid;
	logic             ready;
	tmp_pkg::result_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

@@ rtl/core/tmp_divu.sv @@
// Restoring unsigned divider, one quotient bit per cycle
module tmp_divu #(
	parameter int W = 62
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic         busy,
	output logic [W-1:0] quo
);
	localparam int NW = $clog2(W + 1);

	logic          busy_q;
	logic [NW-1:0] cnt_q;
	logic [W:0]    rem_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [W:0]    rem_sh;
	logic          take;

	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign take   = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + NW'(1);
			if (cnt_q == NW'(W - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[W-2:0], take};
		end
	end

	assign busy = busy_q;
	assign quo  = quo_q;
endmodule

@@ rtl/core/tmp_isqrt.sv @@
// Digit-by-digit integer square root, one root bit per cycle
module tmp_isqrt #(
	parameter int W = 62
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   x,
	output logic           busy,
	output logic [W/2-1:0] root
);
	localparam int RW = W / 2;
	localparam int NW = $clog2(RW + 1);

	logic          busy_q;
	logic [NW-1:0] cnt_q;
	logic [W-1:0]  x_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] root_q;
	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic          take;

	assign rem_sh = {rem_q[RW-1:0], x_q[W-1:W-2]};
	assign trial  = {root_q, 2'b01};
	assign take   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + NW'(1);
			if (cnt_q == NW'(RW - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= {x_q[W-3:0], 2'b00};
			rem_q  <= take ? rem_sh - trial : rem_sh;
			root_q <= {root_q[RW-2:0], take};
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

@@ rtl/core/tmp_dp.sv @@
// Datapath: point ring, window buffer, statistics, divider and square root
`include "assert_macros.svh"

module tmp_dp #(
	parameter int HW = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wen,
	input  logic [tmp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [tmp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  tmp_pkg::point_t                  in_data,
	input  logic                             out_ready,
	input  tmp_pkg::cmd_t                    cmd,
	output tmp_pkg::sts_t                    sts,
	output logic                             out_valid,
	output tmp_pkg::result_t                 out_data
);
	localparam int VW  = tmp_pkg::VAL_W;
	localparam int D   = 2 * HW + 1;
	localparam int AW  = $clog2(D);
	localparam int CW  = $clog2(D + 1);
	localparam int SW  = VW + CW;
	localparam int QW  = 2 * VW + CW;
	localparam int DW  = 2 * VW + 2 * CW;
	localparam int RW  = DW / 2;
	localparam int TW  = tmp_pkg::SIG_W + RW;
	localparam int HPW = tmp_pkg::RAD_W + 3;

	logic [tmp_pkg::RAD_W-1:0] radius_q;
	logic [tmp_pkg::SIG_W-1:0] sigma_q;

	logic [2*VW-1:0] ring_mem [D];
	logic [2*VW-1:0] ring_rd_q;
	logic [VW-1:0]   vals_mem [D];
	logic [VW-1:0]   va_q;
	logic [VW-1:0]   vb_q;

	logic [AW-1:0]             wp_q;
	logic [CW-1:0]             fill_q;
	logic [tmp_pkg::IDX_W-1:0] prcv_q;
	logic                      last_q;
	logic [CW-1:0]             d_q;
	logic [AW-1:0]             slot_q;
	logic [AW-1:0]             centre_q;
	logic [CW-1:0]             cnt_q;
	logic [CW-1:0]             m_q;
	logic [VW-1:0]             rc_q;
	logic [VW-1:0]             qc_q;
	logic [SW-1:0]             sum_q;
	logic [QW-1:0]             sumsq_q;
	logic [2*VW-1:0]           sq_q;
	logic                      add_q;
	logic [AW-1:0]             i_q;
	logic [AW-1:0]             j_q;
	logic [CW-1:0]             lt_q;
	logic [CW-1:0]             le_q;
	logic [VW-1:0]             med_q;
	logic [DW-1:0]             acc_q;
	logic [DW-1:0]             sum2_q;
	logic [RW-1:0]             rms_q;
	logic [TW-1:0]             thr_q;
	logic [SW-1:0]             kept_q;
	logic [CW-1:0]             npts_q;
	logic [VW-1:0]             mean_q;
	logic                      out_v_q;
	tmp_pkg::result_t          res_q;

	logic [HPW-1:0] r6;
	logic [HPW-1:0] hq;
	logic [CW-1:0]  h;
	logic [CW-1:0]  fm1;
	logic [CW-1:0]  d_init;
	logic [CW-1:0]  gap;
	logic [CW-1:0]  older;
	logic [CW-1:0]  span;
	logic [VW-1:0]  g_rr;
	logic [VW-1:0]  g_q;
	logic [VW-1:0]  dr;
	logic           g_keep;
	logic [CW-1:0]  half;
	logic [CW-1:0]  lt_n;
	logic [CW-1:0]  le_n;
	logic           j_last;
	logic           i_last;
	logic           hit;
	logic [VW-1:0]  dev;
	logic           k_keep;
	logic [2*CW-1:0] mm;
	logic            out_free;

	logic           div_start;
	logic [DW-1:0]  div_num;
	logic [DW-1:0]  div_den;
	logic           div_busy;
	logic [DW-1:0]  div_quo;
	logic           sqrt_busy;
	logic [RW-1:0]  sqrt_root;

	function automatic logic [AW-1:0] back_slot(input logic [AW-1:0] w, input logic [CW-1:0] k);
		logic [AW:0] t;
		t = {1'b0, w} + (AW + 1)'(D - 1) - (AW + 1)'(k);
		if (t >= (AW + 1)'(D)) begin
			t = t - (AW + 1)'(D);
		end
		return t[AW-1:0];
	endfunction

	// half window from radius
	assign r6 = ({3'b000, radius_q} << 2) + ({3'b000, radius_q} << 1);
	assign hq = r6 >> 8;
	assign h  = (hq > HPW'(HW)) ? CW'(HW) : CW'(hq);

	assign fm1    = fill_q - CW'(1);
	assign d_init = last_q ? ((fm1 > h) ? h : fm1) : h;
	assign gap    = fm1 - d_q;
	assign older  = (gap > h) ? h : gap;
	assign span   = d_q + older;

	assign g_rr   = ring_rd_q[2*VW-1:VW];
	assign g_q    = ring_rd_q[VW-1:0];
	assign dr     = (g_rr > rc_q) ? g_rr - rc_q : rc_q - g_rr;
	assign g_keep = dr <= VW'(radius_q);

	assign half   = m_q >> 1;
	assign lt_n   = lt_q + CW'(vb_q < va_q);
	assign le_n   = le_q + CW'(vb_q <= va_q);
	assign hit    = (lt_n <= half) && (half < le_n);
	assign j_last = CW'(j_q) == m_q - CW'(1);
	assign i_last = CW'(i_q) == m_q - CW'(1);

	assign dev    = (va_q > med_q) ? va_q - med_q : med_q - va_q;
	assign k_keep = 64'({dev, 8'h00}) < 64'(thr_q);

	assign mm = m_q * (m_q - CW'(1));

	assign out_free = !out_v_q || out_ready;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= tmp_pkg::RADIUS_RST;
			sigma_q  <= tmp_pkg::SIGMA_RST;
		end else if (cfg_wen) begin
			unique case (cfg_addr)
				tmp_pkg::REG_RADIUS: radius_q <= cfg_data;
				tmp_pkg::REG_SIGMA:  sigma_q  <= cfg_data[tmp_pkg::SIG_W-1:0];
			endcase
		end
	end

	// profile control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			fill_q  <= '0;
			prcv_q  <= '0;
			last_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (cmd.store) begin
				wp_q   <= (wp_q == AW'(D - 1)) ? '0 : wp_q + AW'(1);
				fill_q <= (fill_q < CW'(D)) ? fill_q + CW'(1) : fill_q;
				prcv_q <= prcv_q + tmp_pkg::IDX_W'(1);
				last_q <= in_data.last_point;
			end else if (cmd.finish) begin
				wp_q   <= '0;
				fill_q <= '0;
				prcv_q <= '0;
			end
			if (cmd.res_load) begin
				out_v_q <= 1'b1;
			end else if (out_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// ring memory
	always_ff @(posedge clk) begin
		if (cmd.store) begin
			ring_mem[wp_q] <= {in_data.range_value, in_data.charge_value};
		end
		ring_rd_q <= ring_mem[cmd.rd_centre ? centre_q : slot_q];
	end

	// window buffer
	always_ff @(posedge clk) begin
		if (cmd.gcmp && g_keep) begin
			vals_mem[m_q[AW-1:0]] <= g_q;
		end
		va_q <= vals_mem[i_q];
		vb_q <= vals_mem[j_q];
	end

	// gather, rank, moments, clip
	always_ff @(posedge clk) begin
		add_q <= cmd.gcmp && g_keep;
		sq_q  <= g_q * g_q;
		if (add_q) begin
			sumsq_q <= sumsq_q + QW'(sq_q);
		end
		if (cmd.d_load) begin
			d_q <= d_init;
		end else if (cmd.next_d) begin
			d_q <= d_q - CW'(1);
		end
		if (cmd.setup) begin
			slot_q   <= back_slot(wp_q, span);
			centre_q <= back_slot(wp_q, d_q);
			cnt_q    <= span + CW'(1);
			m_q      <= '0;
			sum_q    <= '0;
			sumsq_q  <= '0;
		end
		if (cmd.cload) begin
			rc_q <= g_rr;
			qc_q <= g_q;
		end
		if (cmd.gcmp) begin
			slot_q <= (slot_q == AW'(D - 1)) ? '0 : slot_q + AW'(1);
			cnt_q  <= cnt_q - CW'(1);
			if (g_keep) begin
				m_q   <= m_q + CW'(1);
				sum_q <= sum_q + SW'(g_q);
			end
		end
		if (cmd.mstart || cmd.kstart) begin
			i_q    <= '0;
			j_q    <= '0;
			lt_q   <= '0;
			le_q   <= '0;
			kept_q <= '0;
			npts_q <= '0;
		end
		if (cmd.mcmp) begin
			if (j_last) begin
				j_q  <= '0;
				i_q  <= i_q + AW'(1);
				lt_q <= '0;
				le_q <= '0;
				if (hit) begin
					med_q <= va_q;
				end
			end else begin
				j_q  <= j_q + AW'(1);
				lt_q <= lt_n;
				le_q <= le_n;
			end
		end
		if (cmd.var_start) begin
			acc_q <= '0;
			cnt_q <= m_q;
		end
		if (cmd.msq_step) begin
			acc_q <= acc_q + DW'(sumsq_q);
			cnt_q <= cnt_q - CW'(1);
		end
		if (cmd.sqs) begin
			sum2_q <= sum_q * sum_q;
		end
		if (cmd.rms_load) begin
			rms_q <= sqrt_root;
		end else if (cmd.rms_zero) begin
			rms_q <= '0;
		end
		if (cmd.thr) begin
			thr_q <= sigma_q * rms_q;
		end
		if (cmd.kcmp) begin
			i_q <= i_q + AW'(1);
			if (k_keep) begin
				kept_q <= kept_q + SW'(va_q);
				npts_q <= npts_q + CW'(1);
			end
		end
		if (cmd.mean_own) begin
			mean_q <= qc_q;
		end else if (cmd.mean_zero) begin
			mean_q <= '0;
		end else if (cmd.mean_div) begin
			mean_q <= div_quo[VW-1:0];
		end
		if (cmd.res_load) begin
			res_q.clipped_mean <= mean_q;
			res_q.point_index  <= prcv_q - tmp_pkg::IDX_W'(1) - tmp_pkg::IDX_W'(d_q);
			res_q.last_result  <= last_q && (d_q == '0);
		end
	end

	assign div_start = cmd.vdiv_go || cmd.mdiv_go;
	assign div_num   = cmd.vdiv_go ? acc_q - sum2_q : DW'(kept_q);
	assign div_den   = cmd.vdiv_go ? DW'(mm) : DW'(npts_q);

	tmp_divu #(.W(DW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	tmp_isqrt #(.W(DW)) u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.sqrt_go),
		.x      (div_quo),
		.busy   (sqrt_busy),
		.root   (sqrt_root)
	);

	assign sts.last        = last_q;
	assign sts.emit_needed = last_q || (fill_q > h);
	assign sts.d_zero      = d_q == '0;
	assign sts.gather_last = cnt_q == CW'(1);
	assign sts.m_zero      = m_q == '0;
	assign sts.m_small     = m_q < CW'(2);
	assign sts.j_last      = j_last;
	assign sts.med_hit     = hit;
	assign sts.cnt_zero    = cnt_q == '0;
	assign sts.div_busy    = div_busy;
	assign sts.sqrt_busy   = sqrt_busy;
	assign sts.i_last      = i_last;
	assign sts.npts_zero   = npts_q == '0;
	assign sts.out_free    = out_free;

	assign out_valid = out_v_q;
	assign out_data  = res_q;

	`ASSERT_AT(a_fill_range, fill_q <= CW'(D), "ring fill count beyond ring depth")
	`ASSERT_AT(a_wp_range, wp_q < AW'(D), "write pointer outside ring")
	`ASSERT_AT(a_m_range, m_q <= CW'(D), "window buffer overfilled")
	`ASSERT_IMPL(a_res_free, cmd.res_load, out_free, "result loaded over a pending word")
endmodule

@@ rtl/core/tmp_ctrl.sv @@
// Controller state machine sequencing the datapath
module tmp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  tmp_pkg::sts_t sts,
	output logic          in_ready,
	output tmp_pkg::cmd_t cmd
);
	tmp_pkg::state_t state_q;
	tmp_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			tmp_pkg::ST_IDLE:   if (in_valid) state_d = tmp_pkg::ST_DECIDE;
			tmp_pkg::ST_DECIDE: state_d = sts.emit_needed ? tmp_pkg::ST_SETUP : tmp_pkg::ST_IDLE;
			tmp_pkg::ST_SETUP:  state_d = tmp_pkg::ST_CREAD;
			tmp_pkg::ST_CREAD:  state_d = tmp_pkg::ST_CLOAD;
			tmp_pkg::ST_CLOAD:  state_d = tmp_pkg::ST_GREAD;
			tmp_pkg::ST_GREAD:  state_d = tmp_pkg::ST_GCMP;
			tmp_pkg::ST_GCMP:   state_d = sts.gather_last ? tmp_pkg::ST_GDONE : tmp_pkg::ST_GREAD;
			tmp_pkg::ST_GDONE:  state_d = sts.m_zero ? tmp_pkg::ST_RES : tmp_pkg::ST_MREAD;
			tmp_pkg::ST_MREAD:  state_d = tmp_pkg::ST_MCMP;
			tmp_pkg::ST_MCMP:   state_d = (sts.j_last && sts.med_hit) ? tmp_pkg::ST_VSTART
			                                                           : tmp_pkg::ST_MREAD;
			tmp_pkg::ST_VSTART: state_d = sts.m_small ? tmp_pkg::ST_THR : tmp_pkg::ST_MSQ;
			tmp_pkg::ST_MSQ:    if (sts.cnt_zero) state_d = tmp_pkg::ST_SQS;
			tmp_pkg::ST_SQS:    state_d = tmp_pkg::ST_VDIV;
			tmp_pkg::ST_VDIV:   state_d = tmp_pkg::ST_WVDIV;
			tmp_pkg::ST_WVDIV:  if (!sts.div_busy) state_d = tmp_pkg::ST_SQRT;
			tmp_pkg::ST_SQRT:   state_d = tmp_pkg::ST_WSQRT;
			tmp_pkg::ST_WSQRT:  if (!sts.sqrt_busy) state_d = tmp_pkg::ST_THR;
			tmp_pkg::ST_THR:    state_d = tmp_pkg::ST_KREAD;
			tmp_pkg::ST_KREAD:  state_d = tmp_pkg::ST_KCMP;
			tmp_pkg::ST_KCMP:   state_d = sts.i_last ? tmp_pkg::ST_KDONE : tmp_pkg::ST_KREAD;
			tmp_pkg::ST_KDONE:  state_d = sts.npts_zero ? tmp_pkg::ST_RES : tmp_pkg::ST_WMDIV;
			tmp_pkg::ST_WMDIV:  if (!sts.div_busy) state_d = tmp_pkg::ST_RES;
			tmp_pkg::ST_RES: begin
				if (sts.out_free) begin
					state_d = (sts.last && !sts.d_zero) ? tmp_pkg::ST_SETUP : tmp_pkg::ST_IDLE;
				end
			end
			default:            state_d = tmp_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			tmp_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.store = in_valid;
			end
			tmp_pkg::ST_DECIDE: cmd.d_load    = sts.emit_needed;
			tmp_pkg::ST_SETUP:  cmd.setup     = 1'b1;
			tmp_pkg::ST_CREAD:  cmd.rd_centre = 1'b1;
			tmp_pkg::ST_CLOAD:  cmd.cload     = 1'b1;
			tmp_pkg::ST_GCMP:   cmd.gcmp      = 1'b1;
			tmp_pkg::ST_GDONE: begin
				cmd.mean_own = sts.m_zero;
				cmd.mstart   = !sts.m_zero;
			end
			tmp_pkg::ST_MCMP:   cmd.mcmp = 1'b1;
			tmp_pkg::ST_VSTART: begin
				cmd.rms_zero  = sts.m_small;
				cmd.var_start = !sts.m_small;
			end
			tmp_pkg::ST_MSQ:    cmd.msq_step = !sts.cnt_zero;
			tmp_pkg::ST_SQS:    cmd.sqs      = 1'b1;
			tmp_pkg::ST_VDIV:   cmd.vdiv_go  = 1'b1;
			tmp_pkg::ST_SQRT:   cmd.sqrt_go  = 1'b1;
			tmp_pkg::ST_WSQRT:  cmd.rms_load = !sts.sqrt_busy;
			tmp_pkg::ST_THR: begin
				cmd.thr    = 1'b1;
				cmd.kstart = 1'b1;
			end
			tmp_pkg::ST_KCMP:   cmd.kcmp = 1'b1;
			tmp_pkg::ST_KDONE: begin
				cmd.mean_zero = sts.npts_zero;
				cmd.mdiv_go   = !sts.npts_zero;
			end
			tmp_pkg::ST_WMDIV:  cmd.mean_div = !sts.div_busy;
			tmp_pkg::ST_RES: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					cmd.next_d   = sts.last && !sts.d_zero;
					cmd.finish   = sts.last && sts.d_zero;
				end
			end
			default: begin
				cmd      = '0;
				in_ready = 1'b0;
			end
		endcase
	end
endmodule

@@ rtl/core/truncated_mean_profile.sv @@
// Top level of the truncated mean profile block
// Each accepted point is written to a ring of 2*HALF_WINDOW_MAX+1 entries; then the point
// H places back (H = floor(6*radius/256), at most HALF_WINDOW_MAX) is evaluated, and on a
// last point every remaining point down to the newest is evaluated in turn. Each result
// gathers its window from the ring over one ring port, ranks median candidates over the
// two-port window buffer until the median is found, works out the variance with the
// divider and the square root and the clipped mean with the divider, and may wait for the
// output register. The median rank search dominates, from a 13-point window at the default
// radius up to a full 65-point window. One point is worked at a time; the next point is
// taken once all results of the previous one are loaded into the output register.
module truncated_mean_profile #(
	parameter int HALF_WINDOW_MAX = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	tmp_point_if.sink                      points,
	tmp_result_if.source                   results,
	input  logic                           cfg_wen,
	input  logic [tmp_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [tmp_pkg::CFG_DATA_W-1:0] cfg_data
);
	tmp_pkg::cmd_t cmd;
	tmp_pkg::sts_t sts;
	logic          in_ready;

	tmp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (points.valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	tmp_dp #(.HW(HALF_WINDOW_MAX)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_addr  (cfg_addr),
		.cfg_data  (cfg_data),
		.in_data   (points.data),
		.out_ready (results.ready),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (results.valid),
		.out_data  (results.data)
	);

	assign points.ready = in_ready;
endmodule
